FILE: sv/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// shared types and constants for the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned CAP_W     = 16;  // free-running microsecond timer width
  localparam int unsigned DIST_W    = 21;  // distance in thousandths of a cm
  localparam int unsigned ELAPSED_W = 9;   // saturating millisecond counter
  localparam int unsigned TMO_W     = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned REQ_W     = 2;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [TMO_W-1:0]     TIMEOUT_RST = TMO_W'(60);

  // request codes
  localparam logic [REQ_W-1:0] REQ_START   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STARTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIST     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CAP_W-1:0] capture_value;
  } uer_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                trigger;
    logic [DIST_W-1:0]   distance_milli_cm;
    logic                busy_res;
  } uer_result_t;

endpackage

FILE: sv/uer_in_stage.sv
// ----------------------------------------------------------------------------
// uer_in_stage
// input register; holds one request until the core consumes it
// ----------------------------------------------------------------------------
module uer_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  uer_pkg::uer_item_t in_item,
  input  logic              take,      // core consumes the held request
  output logic              item_v,
  output uer_pkg::uer_item_t item
);
  import uer_pkg::*;

  logic      item_v_r, item_v_nxt;
  uer_item_t item_r;

  // empty, or being drained this cycle
  assign in_ready   = !item_v_r || take;
  assign item_v_nxt = (in_valid && in_ready) || (item_v_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_v = item_v_r;
  assign item   = item_r;

endmodule

FILE: sv/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// measurement state and the per-request decision logic
// ----------------------------------------------------------------------------
module uer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [uer_pkg::TMO_W-1:0]   cfg_wr_data,
  input  logic                        fire,
  input  uer_pkg::uer_item_t          item,
  output uer_pkg::uer_result_t        result
);
  import uer_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_MEAS  = 2'd2
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [CAP_W-1:0]      rise_r, rise_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [TMO_W-1:0]      timeout_r;

  logic                  busy;
  logic [CAP_W-1:0]      width;
  logic [DIST_W-1:0]     dist_mcm;

  assign busy  = (phase_r == PH_ARMED) || (phase_r == PH_MEAS);
  // width wraps with the timer
  assign width = item.capture_value - rise_r;
  // width * 17 as width * 16 + width
  assign dist_mcm = (DIST_W'(width) << 4) + DIST_W'(width);

  always_comb begin
    phase_nxt   = phase_r;
    rise_nxt    = rise_r;
    elapsed_nxt = elapsed_r;
    result      = '0;
    case (item.req_type)
      REQ_START: begin
        if (busy) begin
          result.status = ST_REJECTED;
        end else begin
          phase_nxt      = PH_ARMED;
          elapsed_nxt    = '0;
          result.status  = ST_STARTED;
          result.trigger = 1'b1;
        end
      end
      REQ_CAPTURE: begin
        if (phase_r == PH_ARMED) begin
          rise_nxt  = item.capture_value;
          phase_nxt = PH_MEAS;
        end else if (phase_r == PH_MEAS) begin
          phase_nxt                = PH_IDLE;
          result.status            = ST_DIST;
          result.distance_milli_cm = dist_mcm;
        end
      end
      REQ_TICK: begin
        if (busy) begin
          if (elapsed_r != ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
          if (elapsed_nxt > ELAPSED_W'(timeout_r)) begin
            phase_nxt     = PH_IDLE;
            result.status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        // unused code, no effect
      end
    endcase
    result.busy_res = (phase_nxt == PH_ARMED) || (phase_nxt == PH_MEAS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      rise_r    <= '0;
      elapsed_r <= '0;
      timeout_r <= TIMEOUT_RST;
    end else begin
      if (fire) begin
        phase_r   <= phase_nxt;
        rise_r    <= rise_nxt;
        elapsed_r <= elapsed_nxt;
      end
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

endmodule

FILE: sv/uer_out_stage.sv
// ----------------------------------------------------------------------------
// uer_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module uer_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  uer_pkg::uer_result_t res_in,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uer_pkg::uer_result_t res_out
);
  import uer_pkg::*;

  logic        res_v_r, res_v_nxt;
  uer_result_t res_r;

  assign can_load  = !res_v_r || out_ready;
  assign res_v_nxt = load || (res_v_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = res_v_r;
  assign res_out   = res_r;

endmodule

FILE: sv/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// one-at-a-time ultrasonic ranging control: start, echo captures, timeout
// ----------------------------------------------------------------------------
// a request is held in the input register, its result in the result register
// throughput: one request per cycle while out_tready stays high
// a stalled result holds; the input register takes one more request behind it
// reset (rst_n low, synchronous): phase idle, rising time and elapsed count zero,
//   timeout_ms back to 60, both channel registers empty
module ultrasonic_echo_ranger_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] capture_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] trigger, [21:1] distance_milli_cm,
                                  // [22] busy_res, [23] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // timeout_ms register
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import uer_pkg::*;

  uer_item_t   in_item;
  uer_item_t   item;
  logic        item_v;
  logic        can_load;
  logic        fire;
  uer_result_t result;
  uer_result_t res_out;

  assign in_item.req_type      = in_tuser;
  assign in_item.capture_value = in_tdata;

  // a held request is decided when the result register has room
  assign fire = item_v && can_load;

  uer_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .take     (fire),
    .item_v   (item_v),
    .item     (item)
  );

  // measurement state updates only on fire, so a stalled request is decided exactly once
  uer_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (item),
    .result      (result)
  );

  uer_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_in    (result),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (res_out)
  );

  assign out_tuser = res_out.status;
  assign out_tdata = {1'b0, res_out.busy_res, res_out.distance_milli_cm, res_out.trigger};

endmodule

FILE: sv/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// port-level checks on the ranger result stream
// ----------------------------------------------------------------------------
module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import uer_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // trigger only with an accepted start, which always leaves the block busy
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tuser == ST_STARTED)) &&
                   (out_tuser != ST_STARTED || out_tdata[22]))
    else $error("trigger and start status disagree");

  // distance and timeout both end the measurement
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DIST || out_tuser == ST_TIMEOUT) |-> !out_tdata[22])
    else $error("still busy after measurement ended");

  // distance field is zero unless a distance is reported
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DIST |-> out_tdata[21:1] == '0)
    else $error("distance on a non-distance result");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: sim/ultrasonic_echo_ranger_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit_test
// drives start, echo capture and tick requests into the ranger, predicts each
// result in the bench and checks every result field in order of arrival
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_unit_test;
  import uer_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 12;
  localparam int          DRAIN_CYCLES = 6;       // slack after the result queue empties
  localparam int          HOLD_CYCLES  = 150;     // long receiver hold-off
  localparam int          PHASE_ITEMS  = 117;     // effective requests per random phase, six phases
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 40;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;    // request code the block ignores
  localparam bit          ROW_ITEM     = 1'b0;
  localparam bit          ROW_CFG      = 1'b1;

  typedef enum logic [1:0] {PH_IDLE, PH_ARMED, PH_MEAS} ranger_phase_t;

  // one line of the directed part: a request, or a timeout write (value in cv)
  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  rq;
    logic [15:0] cv;
    bit          typed;     // want holds a hand-written result
    uer_result_t want;
  } stim_row_t;

  localparam int DIR_ROWS = 28;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // requests that idle ignores
    '{ROW_ITEM, REQ_CAPTURE, 16'hFFFF, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b0}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b0}},
    '{ROW_ITEM, REQ_UNUSED,  16'hA5A5, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b0}},
    // start, rejected starts while armed and measuring, width of one
    '{ROW_ITEM, REQ_START,   16'h5A5A, 1'b1, '{ST_STARTED,  1'b1, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_START,   16'hFFFF, 1'b1, '{ST_REJECTED, 1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_CAPTURE, 16'hFFFF, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_START,   16'h0000, 1'b1, '{ST_REJECTED, 1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_CAPTURE, 16'h0000, 1'b1, '{ST_DIST,     1'b0, 21'd17,      1'b0}},
    // widest echo
    '{ROW_ITEM, REQ_START,   16'h0000, 1'b1, '{ST_STARTED,  1'b1, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_CAPTURE, 16'h0000, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_CAPTURE, 16'hFFFF, 1'b1, '{ST_DIST,     1'b0, 21'd1114095, 1'b0}},
    // timer wrap between the rising and falling echo captures
    '{ROW_ITEM, REQ_START,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, REQ_CAPTURE, 16'h8001, 1'b0, '0},
    '{ROW_ITEM, REQ_CAPTURE, 16'h7FFE, 1'b0, '0},
    // timeout of zero: first tick aborts
    '{ROW_CFG,  REQ_START,   16'h0000, 1'b0, '0},
    '{ROW_ITEM, REQ_START,   16'h0000, 1'b1, '{ST_STARTED,  1'b1, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_TIMEOUT,  1'b0, 21'd0,       1'b0}},
    // timeout of one, abort while measuring
    '{ROW_CFG,  REQ_START,   16'h0001, 1'b0, '0},
    '{ROW_ITEM, REQ_START,   16'h0000, 1'b1, '{ST_STARTED,  1'b1, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_CAPTURE, 16'h1234, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b1}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_TIMEOUT,  1'b0, 21'd0,       1'b0}},
    '{ROW_ITEM, REQ_TICK,    16'h0000, 1'b1, '{ST_NONE,     1'b0, 21'd0,       1'b0}},
    // largest timeout, zero width echo
    '{ROW_CFG,  REQ_START,   16'h00FF, 1'b0, '0},
    '{ROW_ITEM, REQ_START,   16'h1234, 1'b0, '0},
    '{ROW_ITEM, REQ_CAPTURE, 16'h1234, 1'b0, '0},
    '{ROW_ITEM, REQ_CAPTURE, 16'h1234, 1'b0, '0}
  };

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [15:0] capture_value
  logic [1:0]  in_tuser    = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // [0] trigger, [21:1] distance_milli_cm, [22] busy_res
  logic [2:0]  out_tuser;          // [2:0] status
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // bench copy of the ranger state
  ranger_phase_t       rg_phase;
  logic [CAP_W-1:0]    rise_stamp;
  logic [ELAPSED_W-1:0] ms_count;
  logic [TMO_W-1:0]    tmo_setting;

  uer_result_t echo_results_q [$];   // expected results, oldest first
  int  error_count       = 0;
  int  effective_requests = 0;       // requests the block did not just ignore
  int  cycle_count       = 0;
  bit  gaps_on           = 1'b1;
  bit  hold_off_req      = 1'b0;

  ultrasonic_echo_ranger_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // next ranger result for one request; advances the bench state
  function automatic uer_result_t predict_echo(input logic [1:0] rq, input logic [15:0] cv);
    uer_result_t r;
    logic        armed_or_meas;
    logic [CAP_W-1:0] width;
    r = '0;
    armed_or_meas = (rg_phase != PH_IDLE);
    case (rq)
      REQ_START: begin
        if (armed_or_meas) begin
          r.status = ST_REJECTED;
        end else begin
          rg_phase  = PH_ARMED;
          ms_count  = '0;
          r.status  = ST_STARTED;
          r.trigger = 1'b1;
        end
      end
      REQ_CAPTURE: begin
        if (rg_phase == PH_ARMED) begin
          rise_stamp = cv;
          rg_phase   = PH_MEAS;
        end else if (rg_phase == PH_MEAS) begin
          // width wraps with the 16-bit timer, times 17 always fits 21 bits
          width               = cv - rise_stamp;
          r.distance_milli_cm = DIST_W'(width) * DIST_W'(17);
          rg_phase            = PH_IDLE;
          r.status            = ST_DIST;
        end
      end
      REQ_TICK: begin
        if (armed_or_meas) begin
          if (ms_count != ELAPSED_MAX) ms_count = ms_count + 1'b1;
          if (ms_count > ELAPSED_W'(tmo_setting)) begin
            rg_phase = PH_IDLE;
            r.status = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
    r.busy_res = (rg_phase != PH_IDLE);
    return r;
  endfunction

  // offer one request, wait for the handshake, then queue its result
  task automatic send_request(input logic [1:0] rq, input logic [15:0] cv,
                              input bit typed, input uer_result_t want);
    uer_result_t pred;
    bit          was_idle;
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rq;
    in_tdata  <= cv;
    do @(posedge clk); while (!in_tready);
    was_idle = (rg_phase == PH_IDLE);
    pred     = predict_echo(rq, cv);
    echo_results_q.push_back(typed ? want : pred);
    if (!was_idle || pred.status != ST_NONE) effective_requests++;
  endtask

  // timeout write once the block has drained
  task automatic write_timeout(input logic [7:0] v);
    in_tvalid <= 1'b0;
    while (echo_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tmo_setting = v;
  endtask

  // ticks between two steps of a measurement; long runs reach the abort
  function automatic int pick_tick_run();
    if (tmo_setting > 8'd40)
      return ($urandom_range(0, 29) == 0) ? int'(tmo_setting) + 1 : $urandom_range(0, 3);
    return $urandom_range(0, 3);
  endfunction

  // well-formed measurement with random content
  task automatic run_measurement();
    logic [15:0] rise;
    logic [15:0] width;
    send_request(REQ_START, 16'($urandom), 1'b0, '0);
    repeat (pick_tick_run()) send_request(REQ_TICK, 16'($urandom), 1'b0, '0);
    if ($urandom_range(0, 9) == 0) send_request(REQ_START, 16'($urandom), 1'b0, '0);
    if (rg_phase == PH_IDLE) return;
    rise = 16'($urandom);
    send_request(REQ_CAPTURE, rise, 1'b0, '0);
    repeat (pick_tick_run()) send_request(REQ_TICK, 16'($urandom), 1'b0, '0);
    if (rg_phase == PH_IDLE) return;
    case ($urandom_range(0, 3))
      0:       width = 16'($urandom_range(0, 20));
      1:       width = 16'hFFFF - 16'($urandom_range(0, 20));
      default: width = 16'($urandom);
    endcase
    send_request(REQ_CAPTURE, rise + width, 1'b0, '0);
  endtask

  task automatic report(input string what, input int want, input int got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    uer_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (echo_results_q.size() == 0) begin
        report("unexpected result, status", -1, out_tuser);
      end else begin
        exp_r = echo_results_q.pop_front();
        if (out_tuser != exp_r.status)
          report("status", exp_r.status, out_tuser);
        if (out_tdata[0] != exp_r.trigger)
          report("trigger", exp_r.trigger, out_tdata[0]);
        if (out_tdata[21:1] != exp_r.distance_milli_cm)
          report("distance_milli_cm", exp_r.distance_milli_cm, out_tdata[21:1]);
        if (out_tdata[22] != exp_r.busy_res)
          report("busy_res", exp_r.busy_res, out_tdata[22]);
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_off_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off_req = 1'b0;
      out_tready <= 1'b1;
    end else if (rst_n && gaps_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [7:0] phase_tmo [6];
    int         target;
    rg_phase    = PH_IDLE;
    rise_stamp  = '0;
    ms_count    = '0;
    tmo_setting = TIMEOUT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset timeout of 60 first
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].is_cfg)
        write_timeout(DIRECTED[i].cv[7:0]);
      else
        send_request(DIRECTED[i].rq, DIRECTED[i].cv, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // random phases, each under its own timeout; the last one without gaps
    phase_tmo[0] = 8'd255;
    phase_tmo[1] = 8'd7;
    phase_tmo[2] = 8'($urandom_range(2, 254));
    phase_tmo[3] = 8'd0;
    phase_tmo[4] = 8'd1;
    phase_tmo[5] = TIMEOUT_RST;
    for (int p = 0; p < 6; p++) begin
      write_timeout(phase_tmo[p]);
      if (p == 1) hold_off_req = 1'b1;   // fill the block while the sender keeps going
      if (p == 5) gaps_on = 1'b0;
      target = effective_requests + PHASE_ITEMS;
      while (effective_requests < target) begin
        if ($urandom_range(0, 9) < 7)
          run_measurement();
        else
          send_request(2'($urandom_range(0, 3)), 16'($urandom), 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (echo_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
sv/uer_pkg.sv
sv/uer_in_stage.sv
sv/uer_core.sv
sv/uer_out_stage.sv
sv/ultrasonic_echo_ranger_unit.sv
sv/uer_checker.sv
sim/ultrasonic_echo_ranger_unit_test.sv
